@@ rtl/salct_pkg.sv @@
`default_nettype none

package salct_pkg;

    // Field widths of the access and result items
    localparam int ADDR_BITS  = 32;
    localparam int STAMP_BITS = 32;
    localparam int CNT_W      = 48;
    localparam int WAY_OUT_W  = 2;

    // Default geometry
    localparam int SET_COUNT_DEF  = 64;
    localparam int WAYS_DEF       = 4;
    localparam int LINE_BYTES_DEF = 64;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  address;
        logic                  write_op;
        logic [STAMP_BITS-1:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic                 hit;
        logic                 writeback;
        logic [WAY_OUT_W-1:0] way_used;
        logic [CNT_W-1:0]     access_total;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     miss_total;
        logic [CNT_W-1:0]     writeback_total;
    } t_out_item;

    // Status of one lookup, from the way selector to the top level
    typedef struct packed {
        logic hit;
        logic writeback;
        logic dirty;
    } t_lookup_flags;

endpackage

`default_nettype wire

@@ rtl/salct_ram.sv @@
`default_nettype none

module salct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                     i_wr_data,
    input  wire logic                                 i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/salct_lookup.sv @@
`default_nettype none

module salct_lookup #(
    parameter int WAYS  = 4,
    parameter int TAG_W = 20,
    parameter int WAY_W = 2
) (
    input  wire logic [WAYS*(1+salct_pkg::STAMP_BITS+TAG_W)-1:0] i_row,
    input  wire logic [WAYS-1:0]                                 i_valid,
    input  wire logic [TAG_W-1:0]                                i_tag,
    output logic      [WAY_W-1:0]                                o_way,
    output salct_pkg::t_lookup_flags                             o_flags
);
    import salct_pkg::*;

    localparam int ENT_W = 1 + STAMP_BITS + TAG_W;
    localparam int PW    = 1 << WAY_W;

    logic [TAG_W-1:0]      tags   [WAYS];
    logic [STAMP_BITS-1:0] stamps [WAYS];
    logic [WAYS-1:0]       dirty;
    logic [WAYS-1:0]       match;

    logic [STAMP_BITS-1:0] nd_stamp [1:2*PW-1];
    logic [WAY_W-1:0]      nd_idx   [1:2*PW-1];
    logic                  nd_pres  [1:2*PW-1];

    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             any_free;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] victim;
    logic [WAY_W-1:0] way;
    logic             way_dirty;
    logic             way_valid;

    // Split the row into its entries and compare tags
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            tags[w]   = i_row[w*ENT_W +: TAG_W];
            stamps[w] = i_row[w*ENT_W + TAG_W +: STAMP_BITS];
            dirty[w]  = i_row[w*ENT_W + ENT_W - 1];
            match[w]  = i_valid[w] && (tags[w] == i_tag);
        end
    end

    // Pick the lowest matching way and the lowest free way
    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        any_free = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!i_valid[w]) begin
                any_free = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    // Find the oldest stamp with a pairwise tree; ties keep the lower way
    always_comb begin
        for (int n = 0; n < PW; n++) begin
            nd_pres[PW+n]  = (n < WAYS);
            nd_idx[PW+n]   = WAY_W'(n);
            nd_stamp[PW+n] = '0;
            for (int w = 0; w < WAYS; w++) begin
                if (w == n) begin
                    nd_stamp[PW+n] = stamps[w];
                end
            end
        end
        for (int n = PW - 1; n >= 1; n--) begin
            if (nd_pres[2*n+1] && (nd_stamp[2*n+1] < nd_stamp[2*n])) begin
                nd_stamp[n] = nd_stamp[2*n+1];
                nd_idx[n]   = nd_idx[2*n+1];
            end else begin
                nd_stamp[n] = nd_stamp[2*n];
                nd_idx[n]   = nd_idx[2*n];
            end
            nd_pres[n] = nd_pres[2*n] || nd_pres[2*n+1];
        end
    end

    // Choose the way and report a dirty eviction
    always_comb begin
        victim    = any_free ? free_way : nd_idx[1];
        way       = hit ? hit_way : victim;
        way_dirty = 1'b0;
        way_valid = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == way) begin
                way_dirty = dirty[w];
                way_valid = i_valid[w];
            end
        end
    end

    assign o_way             = way;
    assign o_flags.hit       = hit;
    assign o_flags.writeback = !hit && way_valid && way_dirty;
    assign o_flags.dirty     = way_dirty;

endmodule

`default_nettype wire

@@ rtl/set_assoc_lru_cache_tags.sv @@
// A transferred access loads the lookup stage and reads the set row; the result register is
// loaded when the access leaves the lookup stage, which an output stall can hold off.
// Throughput: one access per cycle unless the output stalls; set rows come from one tag/state
// RAM with a registered read; a write-to-read forward covers back-to-back same-set accesses.
// Reset: valid bits clear at once, counters return to zero, no clearing pass is needed.
`default_nettype none

module set_assoc_lru_cache_tags #(
    parameter int SET_COUNT  = salct_pkg::SET_COUNT_DEF,
    parameter int WAYS       = salct_pkg::WAYS_DEF,
    parameter int LINE_BYTES = salct_pkg::LINE_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire salct_pkg::t_in_item  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output salct_pkg::t_out_item      o_out_data
);
    import salct_pkg::*;

    localparam int OFF_BITS = $clog2(LINE_BYTES + 1) - 1;
    localparam int IDX_BITS = $clog2(SET_COUNT + 1) - 1;
    localparam int SET_W    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int TAG_W    = (ADDR_BITS > OFF_BITS + IDX_BITS) ?
                              (ADDR_BITS - OFF_BITS - IDX_BITS) : 1;
    localparam int EXT_W    = OFF_BITS + IDX_BITS + TAG_W;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT_W    = 1 + STAMP_BITS + TAG_W;
    localparam int ROW_W    = WAYS * ENT_W;
    localparam logic [SET_W-1:0] SET_MASK = SET_W'((64'd1 << IDX_BITS) - 64'd1);

    // Handshake and pipeline control
    logic adv;
    logic in_acc;
    logic commit;

    // Address decode of the incoming access
    logic [EXT_W-1:0] in_ext;
    logic [SET_W-1:0] in_set;
    logic [TAG_W-1:0] in_tag;

    // Lookup stage
    logic                  r_s1_valid;
    logic [SET_W-1:0]      r_s1_set;
    logic [TAG_W-1:0]      r_s1_tag;
    logic                  r_s1_wr;
    logic [STAMP_BITS-1:0] r_s1_stamp;

    // Row forward from the write that coincided with the read
    logic             r_fwd_sel;
    logic [ROW_W-1:0] r_fwd_row;

    logic [WAYS-1:0]  r_valid [SET_COUNT];
    logic [ROW_W-1:0] ram_rd_data;
    logic [ROW_W-1:0] cur_row;
    logic [ROW_W-1:0] new_row;
    logic [WAYS-1:0]  cur_valid;
    logic [WAY_W-1:0] way;
    t_lookup_flags    flags;

    logic [CNT_W-1:0] r_acc_cnt;
    logic [CNT_W-1:0] r_hit_cnt;
    logic [CNT_W-1:0] r_miss_cnt;
    logic [CNT_W-1:0] r_wb_cnt;
    logic [CNT_W-1:0] n_acc_cnt;
    logic [CNT_W-1:0] n_hit_cnt;
    logic [CNT_W-1:0] n_miss_cnt;
    logic [CNT_W-1:0] n_wb_cnt;

    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    // Advance whenever the result register is free or being emptied
    assign adv        = !r_out_valid || !i_out_stall;
    assign in_acc     = i_in_valid && adv;
    assign commit     = adv && r_s1_valid;
    assign o_in_stall = !adv;

    // Split the address into set index and tag
    assign in_ext = EXT_W'(i_in_data.address);
    assign in_set = SET_W'(in_ext >> OFF_BITS) & SET_MASK;
    assign in_tag = TAG_W'(in_ext >> (OFF_BITS + IDX_BITS));

    salct_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SET_COUNT)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (commit),
        .i_wr_addr (r_s1_set),
        .i_wr_data (new_row),
        .i_rd_en   (in_acc),
        .i_rd_addr (in_set),
        .o_rd_data (ram_rd_data)
    );

    assign cur_row   = r_fwd_sel ? r_fwd_row : ram_rd_data;
    assign cur_valid = r_valid[r_s1_set];

    salct_lookup #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .WAY_W (WAY_W)
    ) u_lookup (
        .i_row   (cur_row),
        .i_valid (cur_valid),
        .i_tag   (r_s1_tag),
        .o_way   (way),
        .o_flags (flags)
    );

    // Refill or refresh the chosen way, keep the others
    always_comb begin
        new_row = cur_row;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == way) begin
                new_row[w*ENT_W +: ENT_W] = {r_s1_wr || (flags.hit && flags.dirty),
                                             r_s1_stamp, r_s1_tag};
            end
        end
    end

    // Update counters and build the result
    always_comb begin
        n_acc_cnt  = r_acc_cnt + CNT_W'(1);
        n_hit_cnt  = r_hit_cnt + CNT_W'(flags.hit);
        n_miss_cnt = r_miss_cnt + CNT_W'(!flags.hit);
        n_wb_cnt   = r_wb_cnt + CNT_W'(flags.writeback);

        n_out.hit             = flags.hit;
        n_out.writeback       = flags.writeback;
        n_out.way_used        = WAY_OUT_W'(way);
        n_out.access_total    = n_acc_cnt;
        n_out.hit_total       = n_hit_cnt;
        n_out.miss_total      = n_miss_cnt;
        n_out.writeback_total = n_wb_cnt;
    end

    // Control state: stage valids, forward select, valid bits, counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_sel   <= 1'b0;
            r_acc_cnt   <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_wb_cnt    <= '0;
            for (int s = 0; s < SET_COUNT; s++) begin
                r_valid[s] <= '0;
            end
        end else if (adv) begin
            r_s1_valid  <= i_in_valid;
            r_out_valid <= r_s1_valid;
            r_fwd_sel   <= commit && i_in_valid && (r_s1_set == in_set);
            if (commit) begin
                r_acc_cnt  <= n_acc_cnt;
                r_hit_cnt  <= n_hit_cnt;
                r_miss_cnt <= n_miss_cnt;
                r_wb_cnt   <= n_wb_cnt;
                r_valid[r_s1_set][way] <= 1'b1;
            end
        end
    end

    // Payload: lookup stage, forwarded row, result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_set   <= in_set;
            r_s1_tag   <= in_tag;
            r_s1_wr    <= i_in_data.write_op;
            r_s1_stamp <= i_in_data.timestamp;
        end
        if (commit) begin
            r_fwd_row <= new_row;
            r_out     <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Every access is either a hit or a miss
    a_cnt_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_cnt == CNT_W'(r_hit_cnt + r_miss_cnt))
        else $error("access count differs from hits plus misses");

    // A hit never evicts
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.hit && o_out_data.writeback))
        else $error("result reports both hit and writeback");

    // Counters move only when an access leaves the lookup stage
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !commit |=> $stable(r_acc_cnt))
        else $error("access count changed without a commit");

    // A forwarded row always belongs to an access in the lookup stage
    a_fwd_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_sel |-> r_s1_valid)
        else $error("row forward selected with empty lookup stage");

endmodule

`default_nettype wire

@@ verif/set_assoc_lru_cache_tags_tb.sv @@
module set_assoc_lru_cache_tags_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import salct_pkg::*;

    function automatic int floor_lg2(input int v);
        int n;
        n = 0;
        while (v > 1) begin
            v = v >> 1;
            n++;
        end
        return n;
    endfunction

    localparam int SETS        = SET_COUNT_DEF;
    localparam int WAYS_N      = WAYS_DEF;
    localparam int LINE        = LINE_BYTES_DEF;
    localparam int ENTRIES     = SETS * WAYS_N;
    localparam int OFF_W       = floor_lg2(LINE);
    localparam int IDX_W       = floor_lg2(SETS);
    localparam int TAG_W       = ADDR_BITS - OFF_W - IDX_W;
    localparam int RAND_ITEMS  = 2000;
    localparam int POOL_TAGS   = 6;
    localparam int POOL_SETS   = 4;
    localparam int HOLD_AT     = 650;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 8;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_in_item  acc;
        bit        has_fixed;
        t_out_item fixed;
    } t_dir_row;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    // Fixed result for the current directed row, travels with the payload
    bit        row_has_fixed = 1'b0;
    t_out_item row_fixed     = '0;

    // Shadow copy of the tag and state arrays
    bit                    line_valid [ENTRIES];
    bit                    line_dirty [ENTRIES];
    logic [ADDR_BITS-1:0]  line_tag   [ENTRIES];
    logic [STAMP_BITS-1:0] line_stamp [ENTRIES];
    logic [CNT_W-1:0]      cnt_access;
    logic [CNT_W-1:0]      cnt_hit;
    logic [CNT_W-1:0]      cnt_miss;
    logic [CNT_W-1:0]      cnt_wb;

    t_out_item lookups_due [$];
    t_dir_row  dir_rows [$];
    t_out_item predicted;
    t_out_item expected;
    int        mismatches  = 0;
    int        idle_cycles = 0;
    int        accesses_in = 0;
    int        results_out = 0;

    set_assoc_lru_cache_tags dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Look up one access in the shadow arrays, update them, return the result
    function automatic t_out_item cache_access(input t_in_item acc);
        logic [ADDR_BITS-1:0]  tag;
        logic [STAMP_BITS-1:0] oldest;
        int                    set;
        int                    base;
        int                    way;
        bit                    hit;
        bit                    wb;
        bit                    free;
        t_out_item             r;
        set  = int'((acc.address >> OFF_W) & ((1 << IDX_W) - 1));
        tag  = acc.address >> (OFF_W + IDX_W);
        base = set * WAYS_N;
        way  = 0;
        hit  = 1'b0;
        wb   = 1'b0;
        free = 1'b0;
        cnt_access = cnt_access + 1'b1;
        for (int i = 0; i < WAYS_N; i++) begin
            if (!hit && line_valid[base + i] && line_tag[base + i] == tag) begin
                hit = 1'b1;
                way = i;
            end
        end
        if (hit) begin
            cnt_hit = cnt_hit + 1'b1;
            line_stamp[base + way] = acc.timestamp;
            if (acc.write_op) begin
                line_dirty[base + way] = 1'b1;
            end
        end else begin
            cnt_miss = cnt_miss + 1'b1;
            // Take the first invalid way, else the oldest, lowest way on ties
            for (int i = 0; i < WAYS_N; i++) begin
                if (!free && !line_valid[base + i]) begin
                    free = 1'b1;
                    way  = i;
                end
            end
            if (!free) begin
                oldest = line_stamp[base];
                for (int i = 1; i < WAYS_N; i++) begin
                    if (line_stamp[base + i] < oldest) begin
                        oldest = line_stamp[base + i];
                        way    = i;
                    end
                end
            end
            if (line_valid[base + way] && line_dirty[base + way]) begin
                wb     = 1'b1;
                cnt_wb = cnt_wb + 1'b1;
            end
            line_valid[base + way] = 1'b1;
            line_tag[base + way]   = tag;
            line_dirty[base + way] = acc.write_op;
            line_stamp[base + way] = acc.timestamp;
        end
        r.hit             = hit;
        r.writeback       = wb;
        r.way_used        = way[WAY_OUT_W-1:0];
        r.access_total    = cnt_access;
        r.hit_total       = cnt_hit;
        r.miss_total      = cnt_miss;
        r.writeback_total = cnt_wb;
        return r;
    endfunction

    function automatic logic [ADDR_BITS-1:0] build_addr(input logic [ADDR_BITS-1:0] tag,
                                                        input int set, input int off);
        return (tag << (OFF_W + IDX_W)) | (ADDR_BITS'(set) << OFF_W) | ADDR_BITS'(off);
    endfunction

    function automatic t_out_item fixed_res(input bit hit, input bit wb, input int way,
                                            input int acc_n, input int hit_n,
                                            input int miss_n, input int wb_n);
        t_out_item r;
        r.hit             = hit;
        r.writeback       = wb;
        r.way_used        = way[WAY_OUT_W-1:0];
        r.access_total    = CNT_W'(acc_n);
        r.hit_total       = CNT_W'(hit_n);
        r.miss_total      = CNT_W'(miss_n);
        r.writeback_total = CNT_W'(wb_n);
        return r;
    endfunction

    task automatic add_row(input logic [ADDR_BITS-1:0] addr, input bit wr,
                           input logic [STAMP_BITS-1:0] ts, input bit has_fixed,
                           input t_out_item fixed);
        t_dir_row row;
        row.acc.address   = addr;
        row.acc.write_op  = wr;
        row.acc.timestamp = ts;
        row.has_fixed     = has_fixed;
        row.fixed         = fixed;
        dir_rows.push_back(row);
    endtask

    // Offer one access after an idle gap and hold it until transferred
    task automatic send_access(input t_in_item acc, input bit has_fixed,
                               input t_out_item fixed, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_data       <= acc;
        row_has_fixed <= has_fixed;
        row_fixed     <= fixed;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic log_mismatch(input string why, input t_out_item want,
                                input t_out_item got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("MISMATCH %s at %0t", why, $realtime);
            $display("  want hit=%0b wb=%0b way=%0d acc=%0h hits=%0h miss=%0h wbs=%0h",
                     want.hit, want.writeback, want.way_used, want.access_total,
                     want.hit_total, want.miss_total, want.writeback_total);
            $display("  got  hit=%0b wb=%0b way=%0d acc=%0h hits=%0h miss=%0h wbs=%0h",
                     got.hit, got.writeback, got.way_used, got.access_total,
                     got.hit_total, got.miss_total, got.writeback_total);
        end
    endtask

    // Predict each transferred access
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            predicted = cache_access(in_data);
            if (row_has_fixed) begin
                predicted = row_fixed;
            end
            lookups_due.push_back(predicted);
            accesses_in++;
        end
    end

    // Check each transferred result against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            results_out++;
            if (lookups_due.size() == 0) begin
                log_mismatch("unexpected result", '0, out_data);
            end else begin
                expected = lookups_due.pop_front();
                if (expected.hit !== out_data.hit
                    || expected.writeback !== out_data.writeback
                    || expected.way_used !== out_data.way_used
                    || expected.access_total !== out_data.access_total
                    || expected.hit_total !== out_data.hit_total
                    || expected.miss_total !== out_data.miss_total
                    || expected.writeback_total !== out_data.writeback_total) begin
                    log_mismatch("result", expected, out_data);
                end
            end
        end
    end

    // Abort when no transfer happens on either side for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random stalls, calm stretches, and one long hold-off
    initial begin
        int hold;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        forever begin
            if (taken == HOLD_AT) begin
                hold = HOLD_CYCLES;
            end else if ((taken / 128) % 4 == 2) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 18);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (out_valid !== 1'b1);
            taken++;
        end
    end

    // Access side: directed table, then random traffic
    initial begin
        logic [ADDR_BITS-1:0]  tag_pool [POOL_TAGS];
        int                    set_pool [POOL_SETS];
        logic [STAMP_BITS-1:0] stamp_now;
        logic [ADDR_BITS-1:0]  tag_max;
        t_in_item              acc;
        int                    gap;

        for (int e = 0; e < ENTRIES; e++) begin
            line_valid[e] = 1'b0;
            line_dirty[e] = 1'b0;
            line_tag[e]   = '0;
            line_stamp[e] = '0;
        end
        cnt_access = '0;
        cnt_hit    = '0;
        cnt_miss   = '0;
        cnt_wb     = '0;
        tag_max    = (ADDR_BITS'(1) << TAG_W) - 1'b1;

        // Extremes of address and stamp, first accesses after reset
        add_row('0, 1'b0, '0, 1'b1, fixed_res(0, 0, 0, 1, 0, 1, 0));
        add_row('1, 1'b1, '1, 1'b1, fixed_res(0, 0, 0, 2, 0, 2, 0));
        add_row(build_addr('0, 0, LINE - 1), 1'b0, 1, 1'b1, fixed_res(1, 0, 0, 3, 1, 2, 0));
        add_row(build_addr(tag_max, SETS - 1, 0), 1'b0, 2, 1'b1,
                fixed_res(1, 0, 0, 4, 2, 2, 0));
        // Fill a set with dirty lines of equal stamp, then evict the lowest way
        for (int t = 1; t <= 4; t++) begin
            add_row(build_addr(t, 1, 0), 1'b1, 100, 1'b0, '0);
        end
        add_row(build_addr(5, 1, 0), 1'b0, 100, 1'b1, fixed_res(0, 1, 0, 9, 2, 7, 1));
        // Age one way by a hit with an older stamp, then evict it
        add_row(build_addr(2, 1, 8), 1'b1, 50, 1'b0, '0);
        add_row(build_addr(6, 1, 0), 1'b0, 200, 1'b0, '0);
        add_row(build_addr(5, 1, 0), 1'b1, 300, 1'b0, '0);
        // Clean lines evicted without writeback
        for (int t = 7; t <= 10; t++) begin
            add_row(build_addr(t, 2, 0), 1'b0, STAMP_BITS'(t + 3), 1'b0, '0);
        end
        add_row(build_addr(11, 2, 0), 1'b1, 14, 1'b0, '0);
        add_row(build_addr(7, 2, 0), 1'b0, 15, 1'b0, '0);
        // Stamp zero is oldest, all-ones stamp is newest
        add_row(build_addr(1, SETS - 1, 0), 1'b1, '0, 1'b0, '0);
        add_row(build_addr(2, SETS - 1, 0), 1'b0, 5, 1'b0, '0);
        add_row(build_addr(3, SETS - 1, 0), 1'b0, 6, 1'b0, '0);
        add_row(build_addr(4, SETS - 1, 0), 1'b0, 7, 1'b0, '0);
        add_row(build_addr(tag_max, SETS - 1, LINE - 1), 1'b1, '1, 1'b0, '0);

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            send_access(dir_rows[r].acc, dir_rows[r].has_fixed, dir_rows[r].fixed,
                        $urandom_range(0, 18));
        end

        stamp_now = 1000;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            // Draw a fresh working set now and then
            if (n % 250 == 0) begin
                for (int k = 0; k < POOL_TAGS; k++) begin
                    tag_pool[k] = ADDR_BITS'($urandom) & tag_max;
                end
                tag_pool[0] = $urandom_range(0, 1) ? tag_max : '0;
                for (int k = 0; k < POOL_SETS; k++) begin
                    set_pool[k] = $urandom_range(0, SETS - 1);
                end
            end
            // Mostly hot sets and tags with rising stamps, the rest noise
            if ($urandom_range(0, 99) < 85) begin
                acc.address   = build_addr(tag_pool[$urandom_range(0, POOL_TAGS - 1)],
                                           set_pool[$urandom_range(0, POOL_SETS - 1)],
                                           $urandom_range(0, LINE - 1));
                acc.timestamp = stamp_now;
                stamp_now     = stamp_now + $urandom_range(0, 2);
            end else begin
                acc.address   = ADDR_BITS'($urandom);
                acc.timestamp = STAMP_BITS'($urandom);
            end
            acc.write_op = 1'($urandom_range(0, 1));
            if ((n >= 600 && n < 760) || (n / 128) % 4 == 1) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 18);
            end
            send_access(acc, 1'b0, '0, gap);
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then give the pipeline time to misbehave
        while (lookups_due.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Ran %0d accesses (%0d directed): %0d hits, %0d misses",
                 accesses_in, dir_rows.size(), cnt_hit, cnt_miss);
        $display("Saw %0d dirty evictions, checked %0d results, %0d mismatches",
                 cnt_wb, results_out, mismatches);
        if (mismatches == 0 && lookups_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
